// ----- rtl/dmsr_pkg.sv -----
`timescale 1ns / 1ps

package dmsr_pkg;

   localparam logic [1:0] MODE_TICK      = 2'd0;
   localparam logic [1:0] MODE_SET_LEFT  = 2'd1;
   localparam logic [1:0] MODE_SET_RIGHT = 2'd2;

   localparam logic REG_ACCEL = 1'b0;

   localparam int unsigned MAX_DUTY_DEFAULT = 255;

   // One millisecond tick per thousandth of a second.
   localparam logic [47:0] MS_PER_S = 48'd1000;

   // Step counts beyond the largest possible speed gap are capped.
   localparam logic [9:0]  STEP_CAP    = 10'd511;
   localparam logic [47:0] CAP_PRODUCT = 48'd511000;

   // Reciprocal of 1000 scaled by 2^29, exact for dividends below 2^19.
   localparam int unsigned RECIP_SHIFT = 29;
   localparam logic [19:0] RECIP_1000  = 20'd536871;

   typedef logic signed [8:0] speed_type;

endpackage

// ----- rtl/dual_motor_speed_ramp_core.sv -----
`timescale 1ns / 1ps

// Two-channel motor speed ramp with H-bridge drive outputs.
// Requests enter on the req_ channel: mode 0 is a time tick carrying a
// millisecond stamp, mode 1 and 2 set the left or right target speed.
// Every request yields exactly one response on the rsp_ channel with the
// direction line and PWM duty of each motor and both current speeds.
// The acceleration register is written through the APB-style port and
// must only be changed while the block is idle.
// A response becomes valid once its request has passed the request stage
// and the response register: the elapsed-time multiply is registered with
// the request, and the ramp step, made by a reciprocal multiply for the
// division by 1000, updates the speed state and loads the response register.
// One request can be accepted in every cycle unless both stages are full.
// If the receiver stalls, the response register holds its value and the
// request stage holds behind it; req_ready falls only when both are full.
// Synchronous reset clears the speeds, targets, time reference and
// acceleration register, and empties both stages.
module dual_motor_speed_ramp_core
   import dmsr_pkg::*;
#(
   parameter int unsigned MAX_DUTY = MAX_DUTY_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,

   input  logic        req_valid,
   output logic        req_ready,
   input  logic [1:0]  req_mode,
   input  logic [31:0] req_now_ms,
   input  logic signed [8:0] req_target_value,

   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic        rsp_left_forward,
   output logic [7:0]  rsp_left_duty,
   output logic        rsp_right_forward,
   output logic [7:0]  rsp_right_duty,
   output logic signed [8:0] rsp_left_now,
   output logic signed [8:0] rsp_right_now,

   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [2:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready
);

   localparam logic signed [17:0] MAX_DUTY_S = 18'(MAX_DUTY);
   localparam speed_type SPEED_LIM = 9'((MAX_DUTY < 255) ? MAX_DUTY : 255);
   localparam speed_type SPEED_NEG = -SPEED_LIM;

   logic [15:0] accel_ff, accel_in;

   logic        s1_valid_ff, s1_valid_in;
   logic [1:0]  s1_mode_ff, s1_mode_in;
   logic [31:0] s1_now_ff, s1_now_in;
   speed_type   s1_target_ff, s1_target_in;
   logic [47:0] s1_prod_ff, s1_prod_in;

   speed_type   left_speed_ff, left_speed_in;
   speed_type   right_speed_ff, right_speed_in;
   speed_type   left_target_ff, left_target_in;
   speed_type   right_target_ff, right_target_in;
   logic [31:0] last_time_ff, last_time_in;
   logic        time_valid_ff, time_valid_in;

   logic        out_valid_ff, out_valid_in;
   speed_type   out_left_ff, out_left_in;
   speed_type   out_right_ff, out_right_in;

   logic        s1_adv;
   logic        req_take;
   logic        prod_nonzero;
   logic        prod_big;
   logic        tick_moves_ref;
   logic [31:0] last_eff;
   logic [31:0] elapsed;
   logic [38:0] recip_prod;
   logic [9:0]  steps;
   speed_type   left_ramp;
   speed_type   right_ramp;
   logic [8:0]  left_drive;
   logic [8:0]  right_drive;

   function automatic speed_type ramp(speed_type cur, speed_type tgt, logic [9:0] n);
      logic signed [10:0] c;
      logic signed [10:0] t;
      logic signed [10:0] d;
      logic signed [10:0] s;
      speed_type          r;
      c = {{2{cur[8]}}, cur};
      t = {{2{tgt[8]}}, tgt};
      d = t - c;
      s = {1'b0, n};
      r = cur;
      if (d > 11'sd0) begin
         r = (s <= d) ? 9'(c + s) : tgt;
      end else if (d < 11'sd0) begin
         r = (s <= -d) ? 9'(c - s) : tgt;
      end
      return r;
   endfunction

   function automatic logic [8:0] drive(speed_type spd);
      logic signed [17:0] s;
      logic signed [17:0] d;
      logic [7:0]         duty;
      s = {{9{spd[8]}}, spd};
      d = spd[8] ? -s : MAX_DUTY_S - s;
      if (d < 18'sd0) begin
         duty = 8'd0;
      end else if (d > 18'sd255) begin
         duty = 8'd255;
      end else begin
         duty = d[7:0];
      end
      return {~spd[8], duty};
   endfunction

   function automatic speed_type saturate(speed_type raw);
      speed_type v;
      v = raw;
      if (raw > SPEED_LIM) begin
         v = SPEED_LIM;
      end else if (raw < SPEED_NEG) begin
         v = SPEED_NEG;
      end
      return v;
   endfunction

   assign pready = 1'b1;
   assign prdata = (paddr[2] == REG_ACCEL) ? {16'd0, accel_ff} : 32'd0;

   assign s1_adv    = !out_valid_ff || rsp_ready;
   assign req_ready = !s1_valid_ff || s1_adv;
   assign req_take  = req_valid && req_ready;

   // Second stage: step count from the registered product.
   assign prod_nonzero = (s1_prod_ff >= MS_PER_S);
   assign prod_big     = (s1_prod_ff >= CAP_PRODUCT);
   assign recip_prod   = {20'd0, s1_prod_ff[18:0]} * {19'd0, RECIP_1000};
   assign steps        = prod_big ? STEP_CAP : recip_prod[RECIP_SHIFT +: 10];
   assign left_ramp    = ramp(left_speed_ff, left_target_ff, steps);
   assign right_ramp   = ramp(right_speed_ff, right_target_ff, steps);

   // A tick leaving the second stage in this cycle may move the time
   // reference, so the request entering now measures from that stamp.
   assign tick_moves_ref = s1_valid_ff && (s1_mode_ff == MODE_TICK)
                           && (!time_valid_ff || prod_nonzero);
   assign last_eff = tick_moves_ref ? s1_now_ff : last_time_ff;
   assign elapsed  = req_now_ms - last_eff;

   always_comb begin
      accel_in = accel_ff;
      if (psel && penable && pwrite && pready && (paddr[2] == REG_ACCEL)) begin
         accel_in = pwdata[15:0];
      end
   end

   always_comb begin
      s1_valid_in  = s1_valid_ff;
      s1_mode_in   = s1_mode_ff;
      s1_now_in    = s1_now_ff;
      s1_target_in = s1_target_ff;
      s1_prod_in   = s1_prod_ff;
      if (req_take) begin
         s1_valid_in  = 1'b1;
         s1_mode_in   = req_mode;
         s1_now_in    = req_now_ms;
         s1_target_in = saturate(req_target_value);
         s1_prod_in   = {16'd0, elapsed} * {32'd0, accel_ff};
      end else if (s1_adv) begin
         s1_valid_in = 1'b0;
      end
   end

   always_comb begin
      left_speed_in   = left_speed_ff;
      right_speed_in  = right_speed_ff;
      left_target_in  = left_target_ff;
      right_target_in = right_target_ff;
      last_time_in    = last_time_ff;
      time_valid_in   = time_valid_ff;
      if (s1_valid_ff && s1_adv) begin
         case (s1_mode_ff)
            MODE_TICK: begin
               if (!time_valid_ff) begin
                  last_time_in  = s1_now_ff;
                  time_valid_in = 1'b1;
               end else if (prod_nonzero) begin
                  left_speed_in  = left_ramp;
                  right_speed_in = right_ramp;
                  last_time_in   = s1_now_ff;
               end
            end
            MODE_SET_LEFT: begin
               left_target_in = s1_target_ff;
               if (accel_ff == 16'd0) begin
                  left_speed_in = s1_target_ff;
               end
            end
            MODE_SET_RIGHT: begin
               right_target_in = s1_target_ff;
               if (accel_ff == 16'd0) begin
                  right_speed_in = s1_target_ff;
               end
            end
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      out_valid_in = out_valid_ff;
      out_left_in  = out_left_ff;
      out_right_in = out_right_ff;
      if (s1_adv) begin
         out_valid_in = s1_valid_ff;
         out_left_in  = left_speed_in;
         out_right_in = right_speed_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         accel_ff        <= 16'd0;
         s1_valid_ff     <= 1'b0;
         left_speed_ff   <= '0;
         right_speed_ff  <= '0;
         left_target_ff  <= '0;
         right_target_ff <= '0;
         last_time_ff    <= 32'd0;
         time_valid_ff   <= 1'b0;
         out_valid_ff    <= 1'b0;
      end else begin
         accel_ff        <= accel_in;
         s1_valid_ff     <= s1_valid_in;
         left_speed_ff   <= left_speed_in;
         right_speed_ff  <= right_speed_in;
         left_target_ff  <= left_target_in;
         right_target_ff <= right_target_in;
         last_time_ff    <= last_time_in;
         time_valid_ff   <= time_valid_in;
         out_valid_ff    <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      s1_mode_ff   <= s1_mode_in;
      s1_now_ff    <= s1_now_in;
      s1_target_ff <= s1_target_in;
      s1_prod_ff   <= s1_prod_in;
      out_left_ff  <= out_left_in;
      out_right_ff <= out_right_in;
   end

   assign left_drive  = drive(out_left_ff);
   assign right_drive = drive(out_right_ff);

   assign rsp_valid         = out_valid_ff;
   assign rsp_left_forward  = left_drive[8];
   assign rsp_left_duty     = left_drive[7:0];
   assign rsp_right_forward = right_drive[8];
   assign rsp_right_duty    = right_drive[7:0];
   assign rsp_left_now      = out_left_ff;
   assign rsp_right_now     = out_right_ff;

`ifndef SYNTHESIS
   a_ready_only_when_full: assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> (s1_valid_ff && out_valid_ff && !rsp_ready))
      else $error("request refused while a stage was free");

   a_speed_in_range: assert property (@(posedge clock) disable iff (reset)
      (left_speed_ff <= SPEED_LIM) && (left_speed_ff >= SPEED_NEG)
      && (right_speed_ff <= SPEED_LIM) && (right_speed_ff >= SPEED_NEG))
      else $error("speed outside the saturation range");

   a_immediate_left: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && s1_adv && (s1_mode_ff == MODE_SET_LEFT) && (accel_ff == 16'd0))
      |=> (left_speed_ff == left_target_ff))
      else $error("left target not applied at once with zero acceleration");

   a_ref_held_by_set: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && s1_adv && (s1_mode_ff != MODE_TICK)) |=> $stable(last_time_ff))
      else $error("time reference moved by a non-tick request");
`endif

endmodule
